// ===== design/twm_pkg.sv =====
// Shared types and character codes for the topic wildcard matcher.
`timescale 1ns / 1ps
`default_nettype none
package twm_pkg;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TOPIC   = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    logic matched;
    logic too_long;
  } res_t;

endpackage
`default_nettype wire

// ===== design/topic_wildcard_match.sv =====
// Top level of the topic wildcard matcher.
`timescale 1ns / 1ps
`default_nettype none
// Pattern and topic bytes are taken one per cycle while busy is low. The
// topic item marked last starts a match, and busy stays high until the
// result. The match walks both byte buffers through their single read
// ports, classifying each pattern level, comparing bytes and rescanning
// topic bytes each time a '*' takes one more topic level, so the match time
// is data dependent; an overlong string ends it before any level is walked.
// The result appears for exactly one cycle with done_o high; the receiver
// cannot stall it.
module topic_wildcard_match #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  twm_pkg::req_t req_i,
  output logic          done_o,
  output twm_pkg::res_t res_o
);
  import twm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic          accept, p_wr, t_wr, kick;
  logic [AW-1:0] p_raddr, t_raddr;
  logic [7:0]    p_rdata, t_rdata;
  logic [LW-1:0] p_len, t_len;
  logic          p_ovf, t_ovf;

  assign accept = start & ~busy;
  assign p_wr   = accept & (req_i.req_type == REQ_PATTERN);
  assign t_wr   = accept & (req_i.req_type == REQ_TOPIC);
  assign kick   = t_wr & req_i.last;

  twm_store #(.MAX_LEN(MAX_LEN)) u_pat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (p_wr),
    .req_i   (req_i),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata),
    .len_o   (p_len),
    .ovf_o   (p_ovf)
  );

  twm_store #(.MAX_LEN(MAX_LEN)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (t_wr),
    .req_i   (req_i),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata),
    .len_o   (t_len),
    .ovf_o   (t_ovf)
  );

  twm_walker #(.MAX_LEN(MAX_LEN)) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kick_i    (kick),
    .p_len_i   (p_len),
    .p_ovf_i   (p_ovf),
    .t_len_i   (t_len),
    .t_ovf_i   (t_ovf),
    .p_rdata_i (p_rdata),
    .t_rdata_i (t_rdata),
    .p_raddr_o (p_raddr),
    .t_raddr_o (t_raddr),
    .busy_o    (busy),
    .done_o    (done_o),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire

// ===== design/twm_store.sv =====
// String buffer: byte memory with length, overflow and open tracking.
`timescale 1ns / 1ps
`default_nettype none
module twm_store #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_i,
  input  twm_pkg::req_t                  req_i,
  input  logic [$clog2(MAX_LEN)-1:0]     raddr_i,
  output logic [7:0]                     rdata_o,
  output logic [$clog2(MAX_LEN+1)-1:0]   len_o,
  output logic                           ovf_o
);
  import twm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [7:0]    mem_q [MAX_LEN];
  logic [7:0]    rdata_q;
  logic [LW-1:0] len_q, len_d, eff_len;
  logic          ovf_q, ovf_d, eff_ovf;
  logic          open_q, open_d;
  logic          room;

  assign eff_len = open_q ? len_q : '0;
  assign eff_ovf = open_q & ovf_q;
  assign room    = (eff_len < LW'(MAX_LEN));

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    open_d = open_q;
    if (wr_i) begin
      len_d  = eff_len + LW'(req_i.has_byte & room);
      ovf_d  = eff_ovf | (req_i.has_byte & ~room);
      open_d = ~req_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      open_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && req_i.has_byte && room) begin
      mem_q[eff_len[AW-1:0]] <= req_i.data_byte;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign len_o   = len_q;
  assign ovf_o   = ovf_q;

endmodule
`default_nettype wire

// ===== design/twm_walker.sv =====
// Level walker: greedy wildcard match with star backtracking over both buffers.
`timescale 1ns / 1ps
`default_nettype none
module twm_walker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           kick_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]   p_len_i,
  input  logic                           p_ovf_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]   t_len_i,
  input  logic                           t_ovf_i,
  input  logic [7:0]                     p_rdata_i,
  input  logic [7:0]                     t_rdata_i,
  output logic [$clog2(MAX_LEN)-1:0]     p_raddr_o,
  output logic [$clog2(MAX_LEN)-1:0]     t_raddr_o,
  output logic                           busy_o,
  output logic                           done_o,
  output twm_pkg::res_t                  res_o
);
  import twm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INIT    = 11'b000_0000_0010,
    S_TOP     = 11'b000_0000_0100,
    S_CLS_A   = 11'b000_0000_1000,
    S_CLS_B   = 11'b000_0001_0000,
    S_CLS_C   = 11'b000_0010_0000,
    S_CMP_RD  = 11'b000_0100_0000,
    S_CMP_CK  = 11'b000_1000_0000,
    S_SCAN_RD = 11'b001_0000_0000,
    S_SCAN_CK = 11'b010_0000_0000,
    S_SPARE   = 11'b100_0000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] pp_q, pp_d, tp_q, tp_d, sp_q, sp_d, st_q, st_d;
  logic [LW-1:0] ci_q, ci_d, ti_q, ti_d;
  logic          star_q, star_d, bt_q, bt_d;
  logic [7:0]    c0_q, c0_d;
  logic          done_q, done_d;
  res_t          res_q, res_d;

  always_comb begin
    logic          fin_go, fin_m, fin_long, bt_go, scan_go;
    logic [LW-1:0] scan_pos, nxt;
    logic          last1, single, is_star, is_plus, pend, tend;
    logic [7:0]    c1, pc, tc;

    state_d  = state_q;
    pp_d     = pp_q;
    tp_d     = tp_q;
    sp_d     = sp_q;
    st_d     = st_q;
    ci_d     = ci_q;
    ti_d     = ti_q;
    star_d   = star_q;
    bt_d     = bt_q;
    c0_d     = c0_q;
    done_d   = 1'b0;
    res_d    = res_q;
    fin_go   = 1'b0;
    fin_m    = 1'b0;
    fin_long = 1'b0;
    bt_go    = 1'b0;
    scan_go  = 1'b0;
    scan_pos = '0;
    p_raddr_o = '0;
    t_raddr_o = '0;

    last1   = (LW'(pp_q + 1'b1) == p_len_i);
    c1      = p_rdata_i;
    single  = last1 || (c1 == CHAR_SLASH);
    nxt     = last1 ? p_len_i : LW'(pp_q + LW'(2));
    is_star = single && (c0_q == CHAR_STAR);
    is_plus = single && (c0_q == CHAR_PLUS);
    pend    = (ci_q == p_len_i);
    tend    = (ti_q == t_len_i);
    pc      = pend ? CHAR_SLASH : p_rdata_i;
    tc      = tend ? CHAR_SLASH : t_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (kick_i) begin
          pp_d    = '0;
          tp_d    = '0;
          star_d  = 1'b0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (p_ovf_i || t_ovf_i) begin
          fin_go   = 1'b1;
          fin_long = 1'b1;
        end else begin
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        if (pp_q == p_len_i) begin
          if (tp_q == t_len_i) begin
            fin_go = 1'b1;
            fin_m  = 1'b1;
          end else begin
            bt_go = 1'b1;
          end
        end else begin
          state_d = S_CLS_A;
        end
      end
      S_CLS_A: begin
        p_raddr_o = pp_q[AW-1:0];
        state_d   = S_CLS_B;
      end
      S_CLS_B: begin
        c0_d      = p_rdata_i;
        p_raddr_o = AW'(pp_q + 1'b1);
        state_d   = S_CLS_C;
      end
      S_CLS_C: begin
        if (tp_q == t_len_i) begin
          fin_go = 1'b1;
          fin_m  = is_star && (nxt == p_len_i);
        end else if (is_plus) begin
          pp_d    = nxt;
          ti_d    = tp_q;
          bt_d    = 1'b0;
          state_d = S_SCAN_RD;
        end else if (is_star) begin
          star_d  = 1'b1;
          sp_d    = nxt;
          st_d    = tp_q;
          pp_d    = nxt;
          state_d = S_TOP;
        end else begin
          ci_d    = pp_q;
          ti_d    = tp_q;
          state_d = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        p_raddr_o = ci_q[AW-1:0];
        t_raddr_o = ti_q[AW-1:0];
        state_d   = S_CMP_CK;
      end
      S_CMP_CK: begin
        if (pc != tc) begin
          bt_go = 1'b1;
        end else if (pc == CHAR_SLASH) begin
          pp_d    = pend ? p_len_i : LW'(ci_q + 1'b1);
          tp_d    = tend ? t_len_i : LW'(ti_q + 1'b1);
          state_d = S_TOP;
        end else begin
          ci_d    = LW'(ci_q + 1'b1);
          ti_d    = LW'(ti_q + 1'b1);
          state_d = S_CMP_RD;
        end
      end
      S_SCAN_RD: begin
        t_raddr_o = ti_q[AW-1:0];
        if (tend) begin
          scan_go  = 1'b1;
          scan_pos = t_len_i;
        end else begin
          state_d = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (t_rdata_i == CHAR_SLASH) begin
          scan_go  = 1'b1;
          scan_pos = LW'(ti_q + 1'b1);
        end else begin
          ti_d    = LW'(ti_q + 1'b1);
          state_d = S_SCAN_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (bt_go) begin
      if (!star_q) begin
        fin_go = 1'b1;
      end else begin
        ti_d    = st_q;
        bt_d    = 1'b1;
        state_d = S_SCAN_RD;
      end
    end

    if (scan_go) begin
      tp_d    = scan_pos;
      state_d = S_TOP;
      if (bt_q) begin
        st_d = scan_pos;
        pp_d = sp_q;
      end
    end

    if (fin_go) begin
      done_d         = 1'b1;
      res_d.matched  = fin_m;
      res_d.too_long = fin_long;
      state_d        = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      star_q  <= 1'b0;
      bt_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      star_q  <= star_d;
      bt_q    <= bt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q  <= pp_d;
    tp_q  <= tp_d;
    sp_q  <= sp_d;
    st_q  <= st_d;
    ci_q  <= ci_d;
    ti_q  <= ti_d;
    c0_q  <= c0_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== design/twm_checker.sv =====
// Port-level checker for the topic wildcard matcher, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module twm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input twm_pkg::req_t req_i,
  input logic          done_i,
  input twm_pkg::res_t res_i
);
  import twm_pkg::*;

  a_long_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && res_i.too_long |-> !res_i.matched)
    else $error("overlong result reports a match");

  a_topic_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.req_type == REQ_TOPIC) && req_i.last |=> busy)
    else $error("topic end transfer did not start a match");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(busy) && !busy)
    else $error("result without a preceding match");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe repeated");

endmodule

bind topic_wildcard_match twm_checker u_twm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_i (done_o),
  .res_i  (res_o)
);
`default_nettype wire
